// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same-cycle implication.
`define PPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and match tables for the connection protocol sniffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   localparam int unsigned NUM_METHODS = 9;
   localparam int unsigned PREFACE_LEN = 14;
   localparam logic [3:0]  COUNT_MAX   = 4'd15;

   localparam logic [8*PREFACE_LEN-1:0] PREFACE = "PRI * HTTP/2.0";

   localparam logic [7:0] SOCKS4_VER = 8'h04;
   localparam logic [7:0] SOCKS5_VER = 8'h05;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam logic [2:0] TYPE_UNKNOWN     = 3'd0;
   localparam logic [2:0] TYPE_SOCKS4      = 3'd1;
   localparam logic [2:0] TYPE_SOCKS4A     = 3'd2;
   localparam logic [2:0] TYPE_SOCKS5      = 3'd3;
   localparam logic [2:0] TYPE_HTTP        = 3'd4;
   localparam logic [2:0] TYPE_UNSUPPORTED = 3'd5;

   typedef struct packed {
      logic [3:0]             byte_count;
      logic [7:0]             first_byte;
      logic                   addr_high_zero;
      logic                   addr_low_nonzero;
      logic                   preface_alive;
      logic [NUM_METHODS-1:0] method_alive;
      logic                   method_hit;
   } state_type;

   localparam state_type STATE_RESET = '{
      byte_count:       4'd0,
      first_byte:       8'd0,
      addr_high_zero:   1'b1,
      addr_low_nonzero: 1'b0,
      preface_alive:    1'b1,
      method_alive:     {NUM_METHODS{1'b1}},
      method_hit:       1'b0
   };

   typedef struct packed {
      logic       found;
      logic [2:0] type_code;
   } result_type;

   // Preface byte at a position below PREFACE_LEN.
   function automatic logic [7:0] preface_byte(input logic [3:0] pos);
      logic [8*PREFACE_LEN-1:0] tmp;
      tmp = PREFACE << {pos, 3'b000};
      return tmp[8*PREFACE_LEN-1 -: 8];
   endfunction

   function automatic logic [63:0] method_text(input logic [3:0] m);
      logic [63:0] txt;
      case (m)
         4'd0:    txt = {"GET", 40'd0};
         4'd1:    txt = {"HEAD", 32'd0};
         4'd2:    txt = {"POST", 32'd0};
         4'd3:    txt = {"PUT", 40'd0};
         4'd4:    txt = {"DELETE", 16'd0};
         4'd5:    txt = {"CONNECT", 8'd0};
         4'd6:    txt = {"OPTIONS", 8'd0};
         4'd7:    txt = {"TRACE", 24'd0};
         4'd8:    txt = {"PATCH", 24'd0};
         default: txt = 64'd0;
      endcase
      return txt;
   endfunction

   function automatic logic [7:0] method_char(input logic [3:0] m, input logic [2:0] pos);
      logic [63:0] tmp;
      tmp = method_text(m) << {pos, 3'b000};
      return tmp[63:56];
   endfunction

   function automatic logic [3:0] method_len(input logic [3:0] m);
      logic [3:0] len;
      case (m)
         4'd0:    len = 4'd3;
         4'd1:    len = 4'd4;
         4'd2:    len = 4'd4;
         4'd3:    len = 4'd3;
         4'd4:    len = 4'd6;
         4'd5:    len = 4'd7;
         4'd6:    len = 4'd7;
         4'd7:    len = 4'd5;
         4'd8:    len = 4'd5;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- design/pps_tracker.sv -----
// ----------------------------------------------------------------------------
// pps_tracker
// Per-buffer match state: updated once per byte, cleared after the last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic              clear,
   input  wire logic [7:0]        data_byte,
   output pps_pkg::state_type     state_next
);

   pps_pkg::state_type state_ff;
   pps_pkg::state_type state_in;
   pps_pkg::state_type upd;
   logic [3:0]         pos;
   logic [3:0]         len;

   always_comb begin
      upd = state_ff;
      pos = state_ff.byte_count;
      len = 4'd0;
      if (pos == 4'd0) begin
         upd.first_byte = data_byte;
      end
      if (pos >= 4'd4 && pos <= 4'd6 && data_byte != 8'd0) begin
         upd.addr_high_zero = 1'b0;
      end
      if (pos == 4'd7 && data_byte != 8'd0) begin
         upd.addr_low_nonzero = 1'b1;
      end
      if (pos < 4'(pps_pkg::PREFACE_LEN) && data_byte != pps_pkg::preface_byte(pos)) begin
         upd.preface_alive = 1'b0;
      end
      for (int m = 0; m < pps_pkg::NUM_METHODS; m++) begin
         len = pps_pkg::method_len(4'(m));
         if (pos < len) begin
            if (data_byte != pps_pkg::method_char(4'(m), pos[2:0])) begin
               upd.method_alive[m] = 1'b0;
            end
         end else if (pos == len) begin
            if (state_ff.method_alive[m] &&
                (data_byte == pps_pkg::CHAR_SPACE || data_byte == pps_pkg::CHAR_TAB)) begin
               upd.method_hit = 1'b1;
            end
         end
      end
      if (pos < pps_pkg::COUNT_MAX) begin
         upd.byte_count = pos + 4'd1;
      end
   end

   assign state_next = take ? upd : state_ff;

   always_comb begin
      if (clear) begin
         state_in = pps_pkg::STATE_RESET;
      end else begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pps_classify.sv -----
// ----------------------------------------------------------------------------
// pps_classify
// Ordered protocol decision over the match state of a finished buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_classify (
   input  wire pps_pkg::state_type st,
   output pps_pkg::result_type     res
);

   logic [3:0] n;

   assign n = st.byte_count;

   always_comb begin
      res.found     = 1'b0;
      res.type_code = pps_pkg::TYPE_UNKNOWN;
      if (n >= 4'd8 && st.first_byte == pps_pkg::SOCKS4_VER) begin
         res.found     = 1'b1;
         res.type_code = (st.addr_high_zero && st.addr_low_nonzero) ?
                         pps_pkg::TYPE_SOCKS4A : pps_pkg::TYPE_SOCKS4;
      end else if (n >= 4'd2 && st.first_byte == pps_pkg::SOCKS5_VER) begin
         res.found     = 1'b1;
         res.type_code = pps_pkg::TYPE_SOCKS5;
      end else if ((st.preface_alive && n >= 4'(pps_pkg::PREFACE_LEN)) || st.method_hit) begin
         res.found     = 1'b1;
         res.type_code = pps_pkg::TYPE_HTTP;
      end else if (n >= 4'd8) begin
         res.found     = 1'b1;
         res.type_code = pps_pkg::TYPE_UNSUPPORTED;
      end
   end

endmodule

`default_nettype wire

// ----- design/proxy_protocol_sniffer_core.sv -----
// ----------------------------------------------------------------------------
// proxy_protocol_sniffer_core
// Classifies the opening bytes of a client connection as SOCKS4/4a/5, HTTP
// or unsupported.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per byte (req_byte_valid high). req_last marks the
//   final beat of a buffer; a beat with req_byte_valid low and req_last high
//   closes the buffer without a byte (an empty buffer gives unknown). A beat
//   with both low is ignored.
//   rsp_ channel: one beat per buffer, issued for the req_last beat, carrying
//   rsp_found and rsp_type_code. rsp_found low means more data is needed.
//   Throughput: one req_ beat per cycle while rsp_ is not held; see Stall.
//   Path: a last beat enters the input register; its result then enters rsp_ff.
//   The rate is set by the match-state register, updated once per byte beat.
//   Stall: while a result waits in the output register, byte beats still
//   flow; only a second last beat waits in the input register, and
//   req_ready drops once that register is held.
//   Reset: clears the valid flags of both registers and the match state; no rsp_ beat pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module proxy_protocol_sniffer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_byte_valid,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_found,
   output logic [2:0]      rsp_type_code
);

   logic                beat_valid_ff;
   logic [7:0]          beat_data_ff;
   logic                beat_byte_ff;
   logic                beat_last_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   pps_pkg::result_type rsp_ff;
   logic                advance;
   logic                fire_last;
   pps_pkg::state_type  state_next;
   pps_pkg::result_type res;

   assign advance   = beat_valid_ff &&
                      (!beat_last_ff || !rsp_valid_ff || rsp_ready);
   assign fire_last = advance && beat_last_ff;
   assign req_ready = !beat_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
      end else if (req_ready) begin
         beat_valid_ff <= req_valid;
      end
      if (req_ready) begin
         beat_data_ff <= req_data_byte;
         beat_byte_ff <= req_byte_valid;
         beat_last_ff <= req_last;
      end
   end

   pps_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .take       (advance && beat_byte_ff),
      .clear      (fire_last),
      .data_byte  (beat_data_ff),
      .state_next (state_next)
   );

   pps_classify u_classify (
      .st  (state_next),
      .res (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire_last) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_ff.found;
   assign rsp_type_code = rsp_ff.type_code;

   `PPS_ASSERT_IMP(a_undecided_code, clock, reset, rsp_valid_ff && !rsp_ff.found, rsp_ff.type_code == pps_pkg::TYPE_UNKNOWN)
   `PPS_ASSERT_IMP(a_code_range, clock, reset, rsp_valid_ff, rsp_ff.type_code <= pps_pkg::TYPE_UNSUPPORTED)
   `PPS_ASSERT_NXT(a_last_gives_rsp, clock, reset, fire_last, rsp_valid_ff)
   `PPS_ASSERT_NXT(a_no_extra_rsp, clock, reset, !fire_last && (!rsp_valid_ff || rsp_ready), !rsp_valid_ff)
   `PPS_ASSERT_IMP(a_no_overwrite, clock, reset, fire_last, !rsp_valid_ff || rsp_ready)

endmodule

`default_nettype wire
